>>> hw/rtl/cdte_pkg.sv
// ----------------------------------------------------------------------------
// cdte_pkg
// Shared constants and calendar helpers for the civil date-time to epoch
// seconds converter.
// ----------------------------------------------------------------------------
package cdte_pkg;

  localparam int unsigned NumStages = 5;

  localparam int unsigned YearW  = 14;
  localparam int unsigned FieldW = 7;
  localparam int unsigned EpochW = 39;

  localparam logic [YearW-1:0] YearMax = 14'd9999;

  // reciprocal multipliers for division by 25, and by 100 for the last one
  // (the first two valid for 12-bit and 10-bit dividends respectively)
  localparam logic [10:0] Recip25Year = 11'd1311;  // >> 15
  localparam logic [5:0]  Recip25Era  = 6'd41;     // >> 10
  localparam logic [5:0]  Recip100Yoe = 6'd41;     // >> 12

  localparam logic signed [23:0] DaysPerEra = 24'sd146097;
  localparam logic signed [23:0] EpochShift = 24'sd719468;
  localparam logic signed [39:0] SecsPerDay = 40'sd86400;

  localparam logic signed [EpochW-1:0] EpochMin = -39'sd62167219200;
  localparam logic signed [EpochW-1:0] EpochMax = 39'sd253402300799;

  typedef logic [NumStages-1:0] stage_en_t;

  // day of year (counted from march 1st) of the first day of each month
  function automatic logic [8:0] month_base(logic [3:0] m);
    logic [8:0] base;
    case (m)
      4'd1:    base = 9'd306;
      4'd2:    base = 9'd337;
      4'd3:    base = 9'd0;
      4'd4:    base = 9'd31;
      4'd5:    base = 9'd61;
      4'd6:    base = 9'd92;
      4'd7:    base = 9'd122;
      4'd8:    base = 9'd153;
      4'd9:    base = 9'd184;
      4'd10:   base = 9'd214;
      4'd11:   base = 9'd245;
      4'd12:   base = 9'd275;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

>>> hw/rtl/cdte_datapath.sv
// ----------------------------------------------------------------------------
// cdte_datapath
// Five-stage arithmetic pipeline: range checks, era split, day of era,
// day count and seconds. Each stage loads when its enable bit is set.
// ----------------------------------------------------------------------------
module cdte_datapath (
  input  logic                                    clk_i,
  input  cdte_pkg::stage_en_t                     en_i,
  input  logic [cdte_pkg::YearW-1:0]              year_i,
  input  logic [cdte_pkg::FieldW-1:0]             month_i,
  input  logic [cdte_pkg::FieldW-1:0]             day_i,
  input  logic [cdte_pkg::FieldW-1:0]             hour_i,
  input  logic [cdte_pkg::FieldW-1:0]             minute_i,
  input  logic [cdte_pkg::FieldW-1:0]             second_i,
  output logic                                    valid_res_o,
  output logic signed [cdte_pkg::EpochW-1:0]      epoch_seconds_o
);
  import cdte_pkg::*;

  // stage 1: field ranges, shifted year, day of year, time of day
  logic              s1_inrange_q, s1_inrange_d;
  logic [YearW-1:0]  s1_year_q;
  logic [7:0]        s1_q100_q, s1_q100_d;
  logic [3:0]        s1_month_q;
  logic [FieldW-1:0] s1_day_q;
  logic [YearW-1:0]  s1_yy_q, s1_yy_d;
  logic              s1_yyneg_q, s1_yyneg_d;
  logic [8:0]        s1_doy_q, s1_doy_d;
  logic [16:0]       s1_tod_q, s1_tod_d;
  logic [22:0]       q100_prod;
  logic [19:0]       tod_full;

  always_comb begin
    s1_inrange_d = (year_i <= YearMax) && (month_i >= 7'd1) && (month_i <= 7'd12) &&
                   (day_i >= 7'd1) && (hour_i <= 7'd23) && (minute_i <= 7'd59) &&
                   (second_i <= 7'd59);
    // year / 100 as (year / 4) / 25
    q100_prod  = 23'(year_i[YearW-1:2]) * 23'(Recip25Year);
    s1_q100_d  = q100_prod[22:15];
    // march-based year: jan and feb belong to the previous year
    if (month_i <= 7'd2) begin
      s1_yy_d    = year_i - 14'd1;
      s1_yyneg_d = (year_i == '0);
    end else begin
      s1_yy_d    = year_i;
      s1_yyneg_d = 1'b0;
    end
    s1_doy_d = month_base(month_i[3:0]) + 9'(day_i) - 9'd1;
    tod_full = 20'(hour_i) * 20'd3600 + 20'(minute_i) * 20'd60 + 20'(second_i);
    s1_tod_d = tod_full[16:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_inrange_q <= s1_inrange_d;
      s1_year_q    <= year_i;
      s1_q100_q    <= s1_q100_d;
      s1_month_q   <= month_i[3:0];
      s1_day_q     <= day_i;
      s1_yy_q      <= s1_yy_d;
      s1_yyneg_q   <= s1_yyneg_d;
      s1_doy_q     <= s1_doy_d;
      s1_tod_q     <= s1_tod_d;
    end
  end

  // stage 2: leap year, month length check, era and year of era
  logic              s2_ok_q, s2_ok_d;
  logic signed [6:0] s2_era_q, s2_era_d;
  logic [8:0]        s2_yoe_q, s2_yoe_d;
  logic [8:0]        s2_doy_q;
  logic [16:0]       s2_tod_q;
  logic              div100, leap;
  logic [12:0]       q100_back;
  logic [15:0]       era_prod;
  logic [YearW-1:0]  yoe_full;

  always_comb begin
    q100_back = 13'(s1_q100_q) * 13'd25;
    div100    = (q100_back == 13'(s1_year_q[YearW-1:2])) && (s1_year_q[1:0] == 2'd0);
    leap      = (s1_year_q[1:0] == 2'd0) && (!div100 || (s1_q100_q[1:0] == 2'd0));
    s2_ok_d   = s1_inrange_q && (s1_day_q <= 7'(month_len(s1_month_q, leap)));
    era_prod  = 16'(s1_yy_q[YearW-1:4]) * 16'(Recip25Era);
    if (s1_yyneg_q) begin
      s2_era_d = -7'sd1;
      s2_yoe_d = 9'd399;
      yoe_full = '0;
    end else begin
      s2_era_d = $signed({1'b0, era_prod[15:10]});
      yoe_full = s1_yy_q - 14'(era_prod[15:10]) * 14'd400;
      s2_yoe_d = yoe_full[8:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_ok_q  <= s2_ok_d;
      s2_era_q <= s2_era_d;
      s2_yoe_q <= s2_yoe_d;
      s2_doy_q <= s1_doy_q;
      s2_tod_q <= s1_tod_q;
    end
  end

  // stage 3: day of era and era offset in days
  logic               s3_ok_q;
  logic [17:0]        s3_doe_q, s3_doe_d;
  logic signed [23:0] s3_eradays_q, s3_eradays_d;
  logic [16:0]        s3_tod_q;
  logic [14:0]        yoe_prod;

  always_comb begin
    yoe_prod     = 15'(s2_yoe_q) * 15'(Recip100Yoe);
    s3_doe_d     = 18'(s2_yoe_q) * 18'd365 + 18'(s2_yoe_q[8:2]) - 18'(yoe_prod[14:12]) +
                   18'(s2_doy_q);
    s3_eradays_d = 24'(s2_era_q) * DaysPerEra - EpochShift;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_ok_q      <= s2_ok_q;
      s3_doe_q     <= s3_doe_d;
      s3_eradays_q <= s3_eradays_d;
      s3_tod_q     <= s2_tod_q;
    end
  end

  // stage 4: days since the epoch
  logic               s4_ok_q;
  logic signed [23:0] s4_days_q, s4_days_d;
  logic [16:0]        s4_tod_q;

  assign s4_days_d = s3_eradays_q + $signed({6'd0, s3_doe_q});

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s4_ok_q   <= s3_ok_q;
      s4_days_q <= s4_days_d;
      s4_tod_q  <= s3_tod_q;
    end
  end

  // stage 5: seconds, forced to zero for a bad timestamp
  logic                     s5_ok_q;
  logic signed [EpochW-1:0] s5_secs_q, s5_secs_d;
  logic signed [39:0]       secs_full;

  always_comb begin
    secs_full = 40'(s4_days_q) * SecsPerDay + 40'($signed({1'b0, s4_tod_q}));
    s5_secs_d = s4_ok_q ? secs_full[EpochW-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s5_ok_q   <= s4_ok_q;
      s5_secs_q <= s5_secs_d;
    end
  end

  assign valid_res_o     = s5_ok_q;
  assign epoch_seconds_o = s5_secs_q;

endmodule

>>> hw/rtl/civil_datetime_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// civil_datetime_to_epoch_seconds
// Checks a split UTC timestamp and converts it to signed seconds since
// 1970-01-01T00:00:00Z.
// Each result passes through the five datapath register stages. Throughput:
// one timestamp per cycle with no stall.
// Each stage holds its item while the stage after it is full and stalled.
// Reset empties the pipeline; no result is pending afterwards.
// ----------------------------------------------------------------------------
module civil_datetime_to_epoch_seconds (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cdte_pkg::YearW-1:0]          year_i,
  input  logic [cdte_pkg::FieldW-1:0]         month_i,
  input  logic [cdte_pkg::FieldW-1:0]         day_i,
  input  logic [cdte_pkg::FieldW-1:0]         hour_i,
  input  logic [cdte_pkg::FieldW-1:0]         minute_i,
  input  logic [cdte_pkg::FieldW-1:0]         second_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                valid_res_o,
  output logic signed [cdte_pkg::EpochW-1:0]  epoch_seconds_o
);
  import cdte_pkg::*;

  logic [NumStages-1:0] vld_q, vld_d;
  stage_en_t            en;
  logic [NumStages:0]   rdy;

  // a stage can take a new item when it is empty or its item moves on
  always_comb begin
    rdy[NumStages] = out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    en = rdy[NumStages-1:0];
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  cdte_datapath u_datapath (
    .clk_i           (clk_i),
    .en_i            (en),
    .year_i          (year_i),
    .month_i         (month_i),
    .day_i           (day_i),
    .hour_i          (hour_i),
    .minute_i        (minute_i),
    .second_i        (second_i),
    .valid_res_o     (valid_res_o),
    .epoch_seconds_o (epoch_seconds_o)
  );

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NumStages-1];

  // a bad timestamp always reports zero seconds
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (epoch_seconds_o == '0))
    else $error("invalid result with nonzero seconds");

  // a good timestamp lands inside the year 0 to 9999 span
  a_valid_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o) |->
      ((epoch_seconds_o >= EpochMin) && (epoch_seconds_o <= EpochMax)))
    else $error("epoch seconds out of range");

  // input is held back only when every stage is occupied
  a_full_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q))
    else $error("input stalled with a free stage");

  // a stalled result is not overwritten
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(epoch_seconds_o) && $stable(valid_res_o)))
    else $error("stalled result changed");

endmodule
